[hdl/suks_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted unique key set: shared package
// Command and status codes, controller states and the control and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package suks_pkg;

	// Request command, carried in the input tuser.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_LIST   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// Result status, carried in the output tuser.
	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_BAD_KEY   = 3'd1,
		STS_DUPLICATE = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_FULL      = 3'd4,
		STS_EMPTY     = 3'd5
	} status_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_CMP,
		S_IRD,
		S_IWR,
		S_DRD,
		S_DWR,
		S_EMIT,
		S_LRD,
		S_LEMIT
	} state_t;

	// Read address select of the key memory.
	typedef enum logic [1:0] {
		RD_NONE,
		RD_IDX,
		RD_SH_M1,
		RD_SH_P1
	} rd_sel_t;

	// Source of the result key.
	typedef enum logic [1:0] {
		KSEL_REQ,
		KSEL_RD,
		KSEL_ZERO
	} key_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic     load;
		rd_sel_t  rd_sel;
		logic     idx_inc;
		logic     sh_from_cnt;
		logic     sh_from_idx;
		logic     sh_inc;
		logic     sh_dec;
		logic     wr_sh;
		logic     wr_key;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     out_load;
		status_t  out_status;
		key_sel_t out_key_sel;
		logic     out_last;
	} suks_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		cmd_t cmd;
		logic key_zero;
		logic idx_eq_cnt;
		logic idx_last;
		logic rd_lt_key;
		logic rd_eq_key;
		logic cnt_full;
		logic cnt_zero;
		logic sh_eq_idx;
		logic sh_last;
		logic out_ready;
	} suks_sts_t;

endpackage

[hdl/sorted_unique_key_set_core.sv]
// Delete of key 0 and list of an empty table go from decode straight to the result.
// Insert and delete search past the smaller keys, then move the keys above the found
// place by one when the key is placed or removed, then give the result.
// List reads each stored key in turn and passes it to the output.
// Throughput: one item at a time; the next transfer can be taken in the cycle after the last result.
// Reset: asynchronous, clears controller, entry count and output valid; keys are not cleared.
// ----------------------------------------------------------------------------
// Sorted unique key set
// Bounded set of unique keys kept in ascending order, with insert, delete
// and in-order listing over stream channels.
// ----------------------------------------------------------------------------
module sorted_unique_key_set_core #(
	parameter int  CAPACITY  = 32,
	parameter int  KEY_WIDTH = 16,
	localparam int TDATA_W   = ((KEY_WIDTH + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,  // key
	input  logic [1:0]         s_tuser,  // command
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,  // key_out
	output logic [2:0]         m_tuser,  // status
	output logic               m_tlast
);
	import suks_pkg::*;

	suks_cmd_t            cmd;
	suks_sts_t            sts;
	logic [KEY_WIDTH-1:0] out_key;

	suks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	suks_dp #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_cmd     (s_tuser),
		.in_key     (s_tdata[KEY_WIDTH-1:0]),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_status (m_tuser),
		.out_key    (out_key),
		.out_last   (m_tlast)
	);

	assign m_tdata = TDATA_W'(out_key);

`ifndef SYNTHESIS
	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_ready)
		else $error("result register overwritten while stalled");

	// The count never grows past capacity nor drops below zero.
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.cnt_full)
		else $error("insert into a full table");

	a_cnt_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> !sts.cnt_zero)
		else $error("delete from an empty table");

	// An accepted request keeps the block busy in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");
`endif

endmodule

[hdl/suks_ctrl.sv]
// ----------------------------------------------------------------------------
// Sorted unique key set: controller
// Sequences the search, the shift of stored keys and the result transfers.
// ----------------------------------------------------------------------------
module suks_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  suks_pkg::suks_sts_t sts,
	output suks_pkg::suks_cmd_t cmd
);
	import suks_pkg::*;

	state_t  state_q;
	state_t  state_d;
	status_t res_q;
	status_t res_d;

	// State and pending result status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= STS_OK;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.rd_sel      = RD_NONE;
		cmd.out_status  = STS_OK;
		cmd.out_key_sel = KSEL_REQ;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					CMD_INSERT: state_d = S_SCAN;
					CMD_DELETE: begin
						if (sts.key_zero) begin
							res_d   = STS_BAD_KEY;
							state_d = S_EMIT;
						end else begin
							state_d = S_SCAN;
						end
					end
					CMD_LIST: begin
						if (sts.cnt_zero) begin
							res_d   = STS_EMPTY;
							state_d = S_EMIT;
						end else begin
							state_d = S_LRD;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			// Linear search for the first stored key not below the request.
			S_SCAN: begin
				if (sts.idx_eq_cnt) begin
					if (sts.cmd == CMD_INSERT) begin
						if (sts.cnt_full) begin
							res_d   = STS_FULL;
							state_d = S_EMIT;
						end else begin
							cmd.sh_from_cnt = 1'b1;
							state_d         = S_IRD;
						end
					end else begin
						res_d   = STS_NOT_FOUND;
						state_d = S_EMIT;
					end
				end else begin
					cmd.rd_sel = RD_IDX;
					state_d    = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.rd_lt_key) begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN;
				end else if (sts.cmd == CMD_INSERT) begin
					if (sts.rd_eq_key) begin
						res_d   = STS_DUPLICATE;
						state_d = S_EMIT;
					end else if (sts.cnt_full) begin
						res_d   = STS_FULL;
						state_d = S_EMIT;
					end else begin
						cmd.sh_from_cnt = 1'b1;
						state_d         = S_IRD;
					end
				end else begin
					if (sts.rd_eq_key) begin
						cmd.sh_from_idx = 1'b1;
						state_d         = S_DRD;
					end else begin
						res_d   = STS_NOT_FOUND;
						state_d = S_EMIT;
					end
				end
			end
			// Insert: move keys up one place from the top down, then place the key.
			S_IRD: begin
				if (sts.sh_eq_idx) begin
					cmd.wr_key  = 1'b1;
					cmd.cnt_inc = 1'b1;
					res_d       = STS_OK;
					state_d     = S_EMIT;
				end else begin
					cmd.rd_sel = RD_SH_M1;
					state_d    = S_IWR;
				end
			end
			S_IWR: begin
				cmd.wr_sh  = 1'b1;
				cmd.sh_dec = 1'b1;
				state_d    = S_IRD;
			end
			// Delete: move keys down one place over the removed entry.
			S_DRD: begin
				if (sts.sh_last) begin
					cmd.cnt_dec = 1'b1;
					res_d       = STS_OK;
					state_d     = S_EMIT;
				end else begin
					cmd.rd_sel = RD_SH_P1;
					state_d    = S_DWR;
				end
			end
			S_DWR: begin
				cmd.wr_sh  = 1'b1;
				cmd.sh_inc = 1'b1;
				state_d    = S_DRD;
			end
			// Single result of an insert, a delete or an empty list.
			S_EMIT: begin
				if (sts.out_ready) begin
					cmd.out_load    = 1'b1;
					cmd.out_status  = res_q;
					cmd.out_key_sel = (res_q == STS_EMPTY) ? KSEL_ZERO : KSEL_REQ;
					cmd.out_last    = 1'b1;
					state_d         = S_IDLE;
				end
			end
			// List: one read and one result transfer per stored key.
			S_LRD: begin
				cmd.rd_sel = RD_IDX;
				state_d    = S_LEMIT;
			end
			S_LEMIT: begin
				if (sts.out_ready) begin
					cmd.out_load    = 1'b1;
					cmd.out_status  = STS_OK;
					cmd.out_key_sel = KSEL_RD;
					cmd.out_last    = sts.idx_last;
					cmd.idx_inc     = 1'b1;
					state_d         = sts.idx_last ? S_IDLE : S_LRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hdl/suks_dp.sv]
// ----------------------------------------------------------------------------
// Sorted unique key set: datapath
// Key memory, request registers, search and shift pointers, entry count and
// the output register.
// ----------------------------------------------------------------------------
module suks_dp #(
	parameter int CAPACITY  = 32,
	parameter int KEY_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           in_cmd,
	input  logic [KEY_WIDTH-1:0] in_key,
	input  suks_pkg::suks_cmd_t  cmd,
	output suks_pkg::suks_sts_t  sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [2:0]           out_status,
	output logic [KEY_WIDTH-1:0] out_key,
	output logic                 out_last
);
	import suks_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic [KEY_WIDTH-1:0] mem [CAPACITY];
	logic [KEY_WIDTH-1:0] key_q;
	cmd_t                 cmd_q;
	logic [KEY_WIDTH-1:0] rd_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        sh_q;
	logic [CW-1:0]        count_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic                 out_last_q;

	logic [CW-1:0]        rd_addr;
	logic [CW-1:0]        wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic                 wr_en;
	logic [CW:0]          sh_p1;
	logic [CW:0]          idx_p1;
	logic                 can_load;

	assign sh_p1    = {1'b0, sh_q} + 1'b1;
	assign idx_p1   = {1'b0, idx_q} + 1'b1;
	assign can_load = !out_valid_q || out_ready;

	// Memory port selection.
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX:   rd_addr = idx_q;
			RD_SH_M1: rd_addr = sh_q - 1'b1;
			RD_SH_P1: rd_addr = sh_p1[CW-1:0];
			default:  rd_addr = idx_q;
		endcase
		wr_en   = cmd.wr_sh || cmd.wr_key;
		wr_addr = cmd.wr_key ? idx_q : sh_q;
		wr_data = cmd.wr_key ? key_q : rd_q;
	end

	// Key memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_sel != RD_NONE) begin
			rd_q <= mem[rd_addr[AW-1:0]];
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_key;
			cmd_q <= cmd_t'(in_cmd);
		end
	end

	// Pointers and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sh_q    <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1[CW-1:0];
			end
			if (cmd.sh_from_cnt) begin
				sh_q <= count_q;
			end else if (cmd.sh_from_idx) begin
				sh_q <= idx_q;
			end else if (cmd.sh_dec) begin
				sh_q <= sh_q - 1'b1;
			end else if (cmd.sh_inc) begin
				sh_q <= sh_p1[CW-1:0];
			end
			if (cmd.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
			case (cmd.out_key_sel)
				KSEL_RD:   out_key_q <= rd_q;
				KSEL_ZERO: out_key_q <= '0;
				default:   out_key_q <= key_q;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_key    = out_key_q;
	assign out_last   = out_last_q;

	// Status toward the controller.
	always_comb begin
		sts.cmd        = cmd_q;
		sts.key_zero   = (key_q == '0);
		sts.idx_eq_cnt = (idx_q == count_q);
		sts.idx_last   = (idx_p1 == {1'b0, count_q});
		sts.rd_lt_key  = (rd_q < key_q);
		sts.rd_eq_key  = (rd_q == key_q);
		sts.cnt_full   = (count_q == CW'(CAPACITY));
		sts.cnt_zero   = (count_q == '0);
		sts.sh_eq_idx  = (sh_q == idx_q);
		sts.sh_last    = (sh_p1 >= {1'b0, count_q});
		sts.out_ready  = can_load;
	end

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Sorted unique key set: self-checking testbench
// Drives insert, delete and list requests over the input stream and checks
// every result transfer against a software copy of the ordered key table.
// A directed opening covers the edge cases. Random traffic then fills the
// table to capacity and drains it again, several times over. Both stream
// sides throttle at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import suks_pkg::*;

	localparam int SET_CAPACITY = 32;
	localparam int KEY_W        = 16;
	localparam int RANDOM_ITEMS = 330;

	// Tracks the ordered key table and the results still owed by the block.
	class sorted_set_tracker;
		typedef struct {
			status_t          status;
			logic [KEY_W-1:0] key;
			logic             last;
		} reply_t;

		logic [KEY_W-1:0] held_keys[$];
		reply_t           pending_replies[$];
		int               mismatches;

		// First position whose key is not below k.
		function int find_slot(logic [KEY_W-1:0] k);
			int pos;
			pos = 0;
			while (pos < held_keys.size() && held_keys[pos] < k)
				pos++;
			return pos;
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t ns: %s", $time, what);
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction

		// Apply one accepted request and queue the results it must produce.
		function void note_request(cmd_t cmd, logic [KEY_W-1:0] k);
			int     pos;
			reply_t r;
			r.key  = k;
			r.last = 1'b1;
			case (cmd)
				CMD_INSERT: begin
					pos = find_slot(k);
					if (pos < held_keys.size() && held_keys[pos] == k)
						r.status = STS_DUPLICATE;
					else if (held_keys.size() >= SET_CAPACITY)
						r.status = STS_FULL;
					else begin
						held_keys.insert(pos, k);
						r.status = STS_OK;
					end
					pending_replies.push_back(r);
				end
				CMD_DELETE: begin
					pos = find_slot(k);
					if (k == '0)
						r.status = STS_BAD_KEY;
					else if (pos >= held_keys.size() || held_keys[pos] != k)
						r.status = STS_NOT_FOUND;
					else begin
						held_keys.delete(pos);
						r.status = STS_OK;
					end
					pending_replies.push_back(r);
				end
				CMD_LIST: begin
					if (held_keys.size() == 0) begin
						r.status = STS_EMPTY;
						r.key    = '0;
						pending_replies.push_back(r);
					end else begin
						foreach (held_keys[i]) begin
							r.status = STS_OK;
							r.key    = held_keys[i];
							r.last   = (i == held_keys.size() - 1);
							pending_replies.push_back(r);
						end
					end
				end
				default: ;
			endcase
		endfunction

		// Compare one result transfer with the oldest queued result.
		function void check_reply(logic [2:0] status, logic [KEY_W-1:0] k, logic last);
			reply_t r;
			if (pending_replies.size() == 0) begin
				flag($sformatf("unexpected result: status %0d key %h last %0d",
					status, k, last));
				return;
			end
			r = pending_replies.pop_front();
			if (status !== r.status || k !== r.key || last !== r.last)
				flag($sformatf({"result mismatch: expected status %0d key %h last %0d, ",
					"got status %0d key %h last %0d"},
					r.status, r.key, r.last, status, k, last));
		endfunction
	endclass

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [KEY_W-1:0] s_tdata  = '0;
	logic [1:0]       s_tuser  = CMD_NONE;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [KEY_W-1:0] m_tdata;
	logic [2:0]       m_tuser;
	logic             m_tlast;

	sorted_set_tracker tracker = new();

	sorted_unique_key_set_core #(
		.CAPACITY (SET_CAPACITY),
		.KEY_WIDTH(KEY_W)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// Receiver back-pressure: a mode is held for a while, then another is picked.
	int rx_mode;
	int rx_mode_left = 0;
	int rx_tick = 0;
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(30, 200);
		end else
			rx_mode_left--;
		rx_tick++;
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			2:       m_tready <= (rx_tick % 4 == 0);
			default: m_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Every result transfer is checked at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_reply(m_tuser, m_tdata, m_tlast);
	end

	// Present one request and hold it until the block takes it; returns at a falling edge.
	task automatic send_item(cmd_t cmd, logic [KEY_W-1:0] k);
		s_tuser  <= cmd;
		s_tdata  <= k;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		tracker.note_request(cmd, k);
		@(negedge clk);
	endtask

	// Drop valid for a number of cycles, with junk on the data lines.
	task automatic idle_gap(int cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= KEY_W'($urandom);
			s_tuser  <= 2'($urandom_range(0, 3));
			repeat (cycles) @(negedge clk);
		end
	endtask

	// Key choice: a stored key with the given percentage, otherwise extremes,
	// small values that collide often, or any 16-bit value.
	function automatic logic [KEY_W-1:0] pick_key(int held_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < held_pct && tracker.held_keys.size() > 0)
			return tracker.held_keys[$urandom_range(0, tracker.held_keys.size() - 1)];
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 4)
			return KEY_W'($urandom_range(0, 15));
		return KEY_W'($urandom);
	endfunction

	initial begin
		int   sent;
		int   burst_left;
		int   drain_cycles;
		int   r;
		bit   growing;
		cmd_t cmd;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening: empty table, head and tail moves, duplicates, bad keys.
		send_item(CMD_LIST, 16'h1357);
		send_item(CMD_DELETE, 16'h0000);
		send_item(CMD_DELETE, 16'h0042);
		send_item(CMD_INSERT, 16'h8000);
		send_item(CMD_INSERT, 16'h0001);
		send_item(CMD_INSERT, 16'hFFFF);
		send_item(CMD_INSERT, 16'h8000);
		send_item(CMD_INSERT, 16'h4000);
		send_item(CMD_LIST, 16'hFFFF);
		send_item(CMD_NONE, 16'hAAAA);
		send_item(CMD_DELETE, 16'h0001);
		send_item(CMD_INSERT, 16'h0000);
		send_item(CMD_INSERT, 16'h0000);
		send_item(CMD_DELETE, 16'h0000);
		send_item(CMD_DELETE, 16'h1234);
		send_item(CMD_DELETE, 16'hFFFF);
		send_item(CMD_LIST, 16'h0000);
		send_item(CMD_DELETE, 16'h4000);
		send_item(CMD_DELETE, 16'h8000);
		send_item(CMD_INSERT, 16'h5555);
		send_item(CMD_INSERT, 16'hAAAA);
		send_item(CMD_LIST, 16'h5A5A);

		// Random traffic: alternate between filling the table past capacity and
		// draining it, with lists and ignored commands mixed in.
		sent       = 0;
		burst_left = 0;
		growing    = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			if (burst_left == 0) begin
				idle_gap(($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
					: $urandom_range(0, 5));
				burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
			end
			if (growing && tracker.held_keys.size() == SET_CAPACITY
				&& $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (!growing && tracker.held_keys.size() <= 2 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 4)
				cmd = CMD_NONE;
			else if (r < 14)
				cmd = CMD_LIST;
			else if ((r < 74) == growing)
				cmd = CMD_INSERT;
			else
				cmd = CMD_DELETE;
			send_item(cmd, pick_key((cmd == CMD_DELETE) ? 65 : 20));
			if (cmd != CMD_NONE)
				sent++;
			burst_left--;
		end
		s_tvalid <= 1'b0;

		// Let every owed result arrive, then watch for stray transfers.
		drain_cycles = 0;
		while (tracker.outstanding() != 0 && drain_cycles < 100_000) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (300) @(negedge clk);
		if (tracker.outstanding() != 0)
			tracker.flag($sformatf("%0d results never arrived", tracker.outstanding()));

		if (tracker.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
